// ----- hw/rtl/pld_pkg.sv -----
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the price level depth book.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam int LEVELS_DEF   = 256;
    localparam int QTY_BITS_DEF = 32;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 144;

    localparam logic [2:0] CMD_ADD_BID  = 3'd0;
    localparam logic [2:0] CMD_ADD_ASK  = 3'd1;
    localparam logic [2:0] CMD_CAN_BID  = 3'd2;
    localparam logic [2:0] CMD_CAN_ASK  = 3'd3;
    localparam logic [2:0] CMD_EXE_BUY  = 3'd4;
    localparam logic [2:0] CMD_EXE_SELL = 3'd5;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } state_t;

    // decoded event, carried from accept to the modify cycle
    typedef struct packed {
        logic       hit;
        logic       side;
        logic       is_add;
        logic       dropped;
        logic       latch;
        logic [7:0] lvl;
    } pld_req_t;

endpackage

// ----- hw/rtl/price_level_depth_book_core.sv -----
// ----------------------------------------------------------------------------
// price_level_depth_book_core
// Bid and ask depth per price level, indexed by tick distance from a latched
// reference price per side.
// ----------------------------------------------------------------------------
// In the accept cycle the event is decoded and the level memory is read; in
// ST_MODIFY, once the output register is free, the level is updated, written
// back and the result word is loaded into the output register. The level
// memories have a registered read. After reset the block runs a clearing
// pass over every level of both level memories with s_tready low. A result
// word waiting in the output register does not block the next accept; it
// only holds the modify cycle.
module price_level_depth_book_core
    import pld_pkg::*;
#(
    parameter int LEVELS   = LEVELS_DEF,
    parameter int QTY_BITS = QTY_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // command[2:0], price[34:3], quantity[66:35], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // best_bid[31:0], best_ask[63:32], events_seen[95:64], level_touched[96],
    // book_side[97], level_index[105:98], level_depth[137:106],
    // add_dropped[138], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int WW    = ((QTY_BITS > 32) ? QTY_BITS : 32) + 1;
    localparam logic [WW-1:0] QMAX = {{(WW - QTY_BITS){1'b0}}, {QTY_BITS{1'b1}}};

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [31:0]           bid_ref_reg, bid_ref_next;
    logic [31:0]           ask_ref_reg, ask_ref_next;
    logic [31:0]           evt_cnt_reg, evt_cnt_next;
    pld_req_t              req_reg, req_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [31:0]           qty_reg, qty_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] out_reg, out_next;

    logic [2:0]            command;
    logic [31:0]           price;
    logic [31:0]           quantity;
    pld_req_t              dec_req;
    logic [IDX_W-1:0]      dec_idx;

    logic                  accept;
    logic                  go;
    logic                  ram_we_bid;
    logic                  ram_we_ask;
    logic [IDX_W-1:0]      ram_waddr;
    logic [QTY_BITS-1:0]   ram_wdata;
    logic [QTY_BITS-1:0]   bid_rdata;
    logic [QTY_BITS-1:0]   ask_rdata;
    logic [WW-1:0]         d_ext;
    logic [WW-1:0]         q_ext;
    logic [WW-1:0]         sum;
    logic [WW-1:0]         new_ext;
    logic [QTY_BITS-1:0]   new_depth;

    assign command  = s_tdata[2:0];
    assign price    = s_tdata[34:3];
    assign quantity = s_tdata[66:35];

    pld_decode #(
        .LEVELS (LEVELS),
        .IDX_W  (IDX_W)
    ) u_decode (
        .command (command),
        .price   (price),
        .bid_ref (bid_ref_reg),
        .ask_ref (ask_ref_reg),
        .req     (dec_req),
        .idx     (dec_idx)
    );

    pld_ram #(
        .WIDTH (QTY_BITS),
        .DEPTH (LEVELS)
    ) u_bid_ram (
        .clk   (clk),
        .we    (ram_we_bid),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (dec_idx),
        .rdata (bid_rdata)
    );

    pld_ram #(
        .WIDTH (QTY_BITS),
        .DEPTH (LEVELS)
    ) u_ask_ram (
        .clk   (clk),
        .we    (ram_we_ask),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (dec_idx),
        .rdata (ask_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // level update
    always_comb
    begin
        d_ext     = WW'(req_reg.side ? ask_rdata : bid_rdata);
        q_ext     = WW'(qty_reg);
        sum       = d_ext + q_ext;
        if (req_reg.is_add)
        begin
            new_ext = (sum > QMAX) ? QMAX : sum;
        end
        else
        begin
            new_ext = (d_ext >= q_ext) ? (d_ext - q_ext) : '0;
        end
        new_depth = new_ext[QTY_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            bid_ref_reg <= '0;
            ask_ref_reg <= '0;
            evt_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            bid_ref_reg <= bid_ref_next;
            ask_ref_reg <= ask_ref_next;
            evt_cnt_reg <= evt_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        qty_reg <= qty_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        bid_ref_next = bid_ref_reg;
        ask_ref_next = ask_ref_reg;
        evt_cnt_next = evt_cnt_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        qty_next     = qty_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        go           = !m_valid_reg || m_tready;
        ram_we_bid   = 1'b0;
        ram_we_ask   = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = new_depth;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we_bid   = 1'b1;
                ram_we_ask   = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(LEVELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next     = dec_req;
                    idx_next     = dec_idx;
                    qty_next     = quantity;
                    evt_cnt_next = evt_cnt_reg + 32'd1;
                    if (dec_req.latch && (dec_req.side == SIDE_ASK))
                    begin
                        ask_ref_next = price;
                    end
                    if (dec_req.latch && (dec_req.side == SIDE_BID))
                    begin
                        bid_ref_next = price;
                    end
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (go)
                begin
                    ram_we_bid        = req_reg.hit && (req_reg.side == SIDE_BID);
                    ram_we_ask        = req_reg.hit && (req_reg.side == SIDE_ASK);
                    out_next          = '0;
                    out_next[31:0]    = bid_ref_reg;
                    out_next[63:32]   = ask_ref_reg;
                    out_next[95:64]   = evt_cnt_reg;
                    out_next[96]      = req_reg.hit;
                    out_next[97]      = req_reg.hit && req_reg.side;
                    out_next[105:98]  = req_reg.hit ? req_reg.lvl : 8'd0;
                    out_next[137:106] = req_reg.hit ? new_ext[31:0] : 32'd0;
                    out_next[138]     = req_reg.dropped;
                    m_valid_next      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // no input word during the clearing pass
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // every accepted word goes through the modify cycle
    a_accept_modify: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MODIFY))
        else $error("accepted word skipped modify cycle");

    // memories are written only by the clear pass or the modify cycle
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we_bid || ram_we_ask) |-> (state_reg == ST_CLEAR || state_reg == ST_MODIFY))
        else $error("level memory written outside clear or modify");

    // a nonzero bid reference never moves
    a_bid_ref_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (bid_ref_reg != 32'd0) |=> (bid_ref_reg == $past(bid_ref_reg)))
        else $error("bid reference moved");

    // a dropped add touches no level
    a_drop_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_reg[138] && out_reg[96]))
        else $error("dropped add reported a touched level");

endmodule

// ----- hw/rtl/pld_ram.sv -----
// ----------------------------------------------------------------------------
// pld_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/pld_decode.sv -----
// ----------------------------------------------------------------------------
// pld_decode
// Command decode and tick distance of one event against the side references.
// ----------------------------------------------------------------------------
module pld_decode
    import pld_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int IDX_W  = 8
) (
    input  logic [2:0]        command,
    input  logic [31:0]       price,
    input  logic [31:0]       bid_ref,
    input  logic [31:0]       ask_ref,
    output pld_req_t          req,
    output logic [IDX_W-1:0]  idx
);

    logic        is_add;
    logic        is_can;
    logic        side;
    logic [31:0] ref_cur;
    logic [31:0] ref_eff;
    logic [32:0] price_x;
    logic [32:0] ref_x;
    logic [32:0] tick_gap;
    logic        dist_neg;
    logic        in_range;
    logic        exe_hit;

    always_comb
    begin
        is_add   = (command == CMD_ADD_BID) || (command == CMD_ADD_ASK);
        is_can   = (command == CMD_CAN_BID) || (command == CMD_CAN_ASK);
        side     = (command == CMD_ADD_ASK) || (command == CMD_CAN_ASK)
                   || (command == CMD_EXE_BUY);
        ref_cur  = side ? ask_ref : bid_ref;
        ref_eff  = (is_add && (ref_cur == 32'd0)) ? price : ref_cur;
        price_x  = {price[31], price};
        ref_x    = {ref_eff[31], ref_eff};
        tick_gap = side ? (price_x - ref_x) : (ref_x - price_x);
        dist_neg = tick_gap[32];
        in_range = !dist_neg && (tick_gap < 33'(LEVELS));
        exe_hit  = (ref_cur != 32'd0) && (price == ref_cur);

        req         = '0;
        req.side    = side;
        req.is_add  = is_add;
        req.latch   = is_add && (ref_cur == 32'd0);
        idx         = '0;
        case (command)
            CMD_ADD_BID, CMD_ADD_ASK, CMD_CAN_BID, CMD_CAN_ASK:
            begin
                req.hit     = in_range;
                req.dropped = is_add && !dist_neg && !in_range;
                req.lvl     = tick_gap[7:0];
                idx         = tick_gap[IDX_W-1:0];
            end
            CMD_EXE_BUY, CMD_EXE_SELL:
            begin
                req.hit = exe_hit;
            end
            default:
            begin
                req.hit = 1'b0;
            end
        endcase
        // cancels never latch or flag
        if (is_can)
        begin
            req.latch = 1'b0;
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of price_level_depth_book_core. Directed events cover
// unset and zero-latched references, saturation, floors, dropped adds and
// distances that would wrap in 32 bits. Random events then hit the latched
// references. Every result word is checked against a behavioral book model,
// with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import pld_pkg::*;

    localparam int LEVELS     = LEVELS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 12;
    localparam int RANDOM_N   = 1925;

    localparam logic [2:0] CMD_NOP_6 = 3'd6;
    localparam logic [2:0] CMD_NOP_7 = 3'd7;

    localparam logic [31:0] QTY_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] PRICE_MIN = 32'h8000_0000;
    localparam logic [31:0] PRICE_MAX = 32'h7FFF_FFFF;

    // quantity, price, command from the top bit down
    typedef struct packed {
        logic [31:0]        quantity;
        logic signed [31:0] price;
        logic [2:0]         command;
    } book_event_t;

    typedef struct packed {
        logic               add_dropped;
        logic [31:0]        level_depth;
        logic [7:0]         level_index;
        logic               book_side;
        logic               level_touched;
        logic [31:0]        events_seen;
        logic signed [31:0] best_ask;
        logic signed [31:0] best_bid;
    } book_result_t;

    localparam int RESULT_W = $bits(book_result_t);

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    price_level_depth_book_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    book_event_t  pending_events[$];
    book_result_t expected_results[$];
    book_event_t  sent_event;

    logic [31:0]        bid_depth [LEVELS];
    logic [31:0]        ask_depth [LEVELS];
    logic signed [31:0] bid_ref       = '0;
    logic signed [31:0] ask_ref       = '0;
    logic [31:0]        model_evt_cnt = '0;

    logic signed [31:0] bid_anchor;
    logic signed [31:0] ask_anchor;

    int total_events   = 0;
    int accepted_count = 0;
    int mismatches     = 0;
    int send_wait      = 0;
    int recv_wait      = 0;
    int idle_cycles    = 0;
    bit send_burst     = 0;
    bit recv_burst     = 0;

    function automatic book_result_t book_apply(book_event_t ev);
        book_result_t r;
        longint       tick_gap;
        logic         is_ask;
        logic         is_add;
        logic [32:0]  sum;
        logic [31:0]  depth;
        r        = '0;
        tick_gap = -1;
        is_ask   = 1'b0;
        is_add   = 1'b0;
        model_evt_cnt = model_evt_cnt + 32'd1;
        case (ev.command)
            CMD_ADD_BID:
            begin
                if (bid_ref == 0)
                    bid_ref = ev.price;
                tick_gap = longint'(bid_ref) - longint'(ev.price);
                is_add   = 1'b1;
            end
            CMD_ADD_ASK:
            begin
                if (ask_ref == 0)
                    ask_ref = ev.price;
                tick_gap = longint'(ev.price) - longint'(ask_ref);
                is_ask   = 1'b1;
                is_add   = 1'b1;
            end
            CMD_CAN_BID:
                tick_gap = longint'(bid_ref) - longint'(ev.price);
            CMD_CAN_ASK:
            begin
                tick_gap = longint'(ev.price) - longint'(ask_ref);
                is_ask   = 1'b1;
            end
            CMD_EXE_BUY:
            begin
                is_ask = 1'b1;
                if (ask_ref != 0 && ev.price == ask_ref)
                    tick_gap = 0;
            end
            CMD_EXE_SELL:
            begin
                if (bid_ref != 0 && ev.price == bid_ref)
                    tick_gap = 0;
            end
            default:
                tick_gap = -1;
        endcase
        if (is_add && tick_gap >= LEVELS)
            r.add_dropped = 1'b1;
        else if (tick_gap >= 0 && tick_gap < LEVELS)
        begin
            depth = is_ask ? ask_depth[int'(tick_gap)] : bid_depth[int'(tick_gap)];
            if (is_add)
            begin
                sum   = {1'b0, depth} + {1'b0, ev.quantity};
                depth = sum[32] ? QTY_MAX : sum[31:0];
            end
            else
                depth = (depth >= ev.quantity) ? depth - ev.quantity : 32'd0;
            if (is_ask)
                ask_depth[int'(tick_gap)] = depth;
            else
                bid_depth[int'(tick_gap)] = depth;
            r.level_touched = 1'b1;
            r.book_side     = is_ask ? SIDE_ASK : SIDE_BID;
            r.level_index   = tick_gap[7:0];
            r.level_depth   = depth;
        end
        r.best_bid    = bid_ref;
        r.best_ask    = ask_ref;
        r.events_seen = model_evt_cnt;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic logic [31:0] random_quantity();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(1, 1000);
        else if (pick < 75)
            return 32'd0;
        else if (pick < 78)
            return QTY_MAX;
        return $urandom;
    endfunction

    function automatic book_event_t random_event();
        book_event_t ev;
        int          pick;
        int          lvl;
        pick        = $urandom_range(0, 99);
        ev.command  = 3'($urandom_range(0, 5));
        ev.quantity = random_quantity();
        ev.price    = $urandom;
        if (pick < 8)
            ev.command = 3'($urandom_range(0, 7));
        else if (pick < 11)
            ev.command = $urandom_range(0, 1) ? CMD_NOP_6 : CMD_NOP_7;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: lvl = $urandom_range(0, 7);
                6, 7:             lvl = $urandom_range(0, LEVELS - 1);
                8:                lvl = $urandom_range(LEVELS - 4, LEVELS + 4);
                default:          lvl = -int'($urandom_range(1, 3));
            endcase
            case (ev.command)
                CMD_ADD_BID, CMD_CAN_BID: ev.price = bid_anchor - lvl;
                CMD_ADD_ASK, CMD_CAN_ASK: ev.price = ask_anchor + lvl;
                CMD_EXE_BUY:
                    ev.price = ask_anchor + (($urandom_range(0, 7) == 0) ? 1 : 0);
                default:
                    ev.price = bid_anchor - (($urandom_range(0, 7) == 0) ? 1 : 0);
            endcase
        end
        return ev;
    endfunction

    task automatic push_event(logic [2:0] command, logic [31:0] price, logic [31:0] quantity);
        book_event_t ev;
        ev.command  = command;
        ev.price    = price;
        ev.quantity = quantity;
        pending_events.push_back(ev);
        total_events++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(book_apply(sent_event));
                accepted_count++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_events.size() > 0)
                begin
                    sent_event = pending_events.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= IN_TDATA_W'(sent_event);
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_wait = draw_wait(send_burst);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        book_result_t got;
        book_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = book_result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("best_bid", want.best_bid, got.best_bid);
                    compare_field("best_ask", want.best_ask, got.best_ask);
                    compare_field("events_seen", want.events_seen, got.events_seen);
                    compare_field("level_touched", 32'(want.level_touched),
                                  32'(got.level_touched));
                    compare_field("book_side", 32'(want.book_side), 32'(got.book_side));
                    compare_field("level_index", 32'(want.level_index),
                                  32'(got.level_index));
                    compare_field("level_depth", want.level_depth, got.level_depth);
                    compare_field("add_dropped", 32'(want.add_dropped),
                                  32'(got.add_dropped));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            bid_depth[i] = '0;
            ask_depth[i] = '0;
        end
        bid_anchor = ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(1000, 100000));
        ask_anchor = bid_anchor + int'($urandom_range(1, 50));

        // nothing latched yet
        push_event(CMD_NOP_6, PRICE_MAX, QTY_MAX);
        push_event(CMD_NOP_7, PRICE_MIN, 32'd1);
        push_event(CMD_EXE_BUY, 32'd0, 32'd5);
        push_event(CMD_EXE_SELL, 32'd0, 32'd5);
        push_event(CMD_CAN_BID, 32'd0, 32'd1);
        // zero price leaves the reference unset
        push_event(CMD_ADD_BID, 32'd0, 32'd10);
        push_event(CMD_ADD_ASK, 32'd0, 32'd3);
        push_event(CMD_ADD_BID, bid_anchor, 32'd100);
        push_event(CMD_ADD_ASK, ask_anchor, 32'd200);
        // saturation at the deepest level
        push_event(CMD_ADD_BID, bid_anchor - (LEVELS - 1), QTY_MAX);
        push_event(CMD_ADD_BID, bid_anchor - (LEVELS - 1), 32'd1);
        push_event(CMD_ADD_BID, bid_anchor - LEVELS, 32'd7);
        push_event(CMD_ADD_ASK, ask_anchor + LEVELS, 32'd7);
        push_event(CMD_ADD_ASK, ask_anchor + (LEVELS - 1), 32'd9);
        push_event(CMD_ADD_BID, bid_anchor + 1, 32'd4);
        push_event(CMD_ADD_ASK, ask_anchor - 1, 32'd4);
        // distances that wrap in 32 bits
        push_event(CMD_ADD_BID, PRICE_MIN, 32'd2);
        push_event(CMD_ADD_ASK, PRICE_MAX, 32'd2);
        push_event(CMD_ADD_BID, PRICE_MAX, 32'd2);
        push_event(CMD_CAN_BID, PRICE_MIN, 32'd2);
        push_event(CMD_CAN_BID, bid_anchor - 3, 32'd5);
        push_event(CMD_CAN_BID, bid_anchor - LEVELS, 32'd5);
        push_event(CMD_CAN_ASK, ask_anchor - 1, 32'd5);
        push_event(CMD_EXE_SELL, bid_anchor, 32'd30);
        push_event(CMD_EXE_SELL, bid_anchor + 1, 32'd30);
        push_event(CMD_EXE_BUY, ask_anchor, 32'd500);
        push_event(CMD_EXE_BUY, ask_anchor - 1, 32'd1);
        push_event(CMD_CAN_ASK, ask_anchor + (LEVELS - 1), QTY_MAX);

        for (int i = 0; i < RANDOM_N; i++)
            pending_events.push_back(random_event());
        total_events += RANDOM_N;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_events || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pld_pkg.sv
hw/rtl/pld_ram.sv
hw/rtl/pld_decode.sv
hw/rtl/price_level_depth_book_core.sv
verif/testbench.sv
